>>> hdl/skf_pkg.sv
// Shared types and constants for the scalar Kalman RSSI filter.
// No dependencies; imported by the controller, the datapath and the top level.
package skf_pkg;

    // Fraction bits of the estimate, the variance and the noise registers.
    localparam int FRAC_BITS = 8;

    localparam int SAMPLE_W  = 8 + FRAC_BITS;
    localparam int DIFF_W    = ((SAMPLE_W > 16) ? SAMPLE_W : 16) + 1;
    localparam int PROD_W    = DIFF_W + 17;
    localparam int DELTA_W   = PROD_W - 16;
    localparam int EST_SUM_W = DELTA_W + 1;

    // Reset values; the estimate reset saturates to the signed 16-bit range.
    localparam int EST_RESET_FULL = -100 * (1 << FRAC_BITS);
    localparam logic signed [15:0] EST_RESET =
        (EST_RESET_FULL < -32768) ? 16'sh8000 : 16'(EST_RESET_FULL);
    localparam logic [15:0] VAR_RESET = 16'(1 << FRAC_BITS);
    localparam logic [15:0] PN_RESET  = 16'(1 << (FRAC_BITS - 1));
    localparam logic [15:0] MN_RESET  = 16'(4 << FRAC_BITS);

    // The gain divider produces one quotient bit per cycle.
    localparam int DIV_STEPS = 16;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Configuration register indexes.
    localparam logic REG_PROCESS_NOISE     = 1'b0;
    localparam logic REG_MEASUREMENT_NOISE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREDICT,
        ST_DIV_INIT,
        ST_DIVIDE,
        ST_GAIN,
        ST_MULT,
        ST_UPDATE,
        ST_DONE
    } skf_state_t;

    typedef struct packed {
        logic load_sample;
        logic predict;
        logic div_init;
        logic div_step;
        logic gain;
        logic mult;
        logic update;
        logic load_out;
    } skf_cmd_t;

endpackage

>>> hdl/skf_ctrl.sv
// Sequencing state machine of the scalar Kalman RSSI filter.
// Depends on skf_pkg; drives the datapath through a skf_cmd_t command word.
module skf_ctrl
    import skf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output skf_cmd_t cmd
);

    skf_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next = ST_PREDICT;
                end
            end
            ST_PREDICT:
            begin
                cmd.predict = 1'b1;
                state_next  = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                cmd.gain   = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold here until the output register is free or being emptied.
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

>>> hdl/skf_datapath.sv
// Arithmetic and state of the scalar Kalman RSSI filter: predict, gain
// divider, estimate and variance update. Depends on skf_pkg.
module skf_datapath
    import skf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  skf_cmd_t    cmd,
    input  logic [7:0]  raw_rssi,
    input  logic [15:0] process_noise,
    input  logic [15:0] measurement_noise,
    output logic [15:0] filtered_rssi,
    output logic [15:0] error_variance
);

    // Filter state.
    logic signed [15:0] est_reg, est_next;
    logic [15:0]        var_reg, var_next;

    // Work registers for one sample.
    logic signed [7:0]        raw_reg;
    logic [15:0]              p_reg, p_next;
    logic [16:0]              sum_reg;
    logic [16:0]              rem_reg, rem_next;
    logic [15:0]              quo_reg;
    logic [15:0]              k_reg, k_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [32:0]              vprod_reg, vprod_next;
    logic [15:0]              out_est_reg, out_var_reg;

    logic [16:0]                 psum;
    logic [17:0]                 rem_shift;
    logic                        rem_ge;
    logic signed [SAMPLE_W-1:0]  sample;
    logic [PROD_W-1:0]           biased;
    logic signed [DELTA_W-1:0]   delta;
    logic signed [EST_SUM_W-1:0] est_sum;

    localparam logic signed [EST_SUM_W-1:0] EST_MAX = EST_SUM_W'(32767);
    localparam logic signed [EST_SUM_W-1:0] EST_MIN = EST_SUM_W'(-32768);

    always_comb
    begin
        psum   = {1'b0, var_reg} + {1'b0, process_noise};
        p_next = psum[16] ? 16'hFFFF : psum[15:0];

        // One restoring step: the remainder stays below the divisor when the measurement noise is nonzero.
        rem_shift = {rem_reg, 1'b0};
        rem_ge    = (rem_shift >= {1'b0, sum_reg});
        rem_next  = rem_ge ? 17'(rem_shift - {1'b0, sum_reg}) : rem_shift[16:0];

        // With no measurement noise the gain is one, clipped to Q0.16,
        // or zero when the variance is zero as well.
        if (measurement_noise == 16'd0)
        begin
            k_next = (p_reg == 16'd0) ? 16'd0 : 16'hFFFF;
        end
        else
        begin
            k_next = quo_reg;
        end

        sample    = $signed({raw_reg, {FRAC_BITS{1'b0}}});
        diff_next = DIFF_W'(sample) - DIFF_W'(est_reg);

        prod_next  = $signed({1'b0, k_reg}) * diff_reg;
        vprod_next = p_reg * (17'h10000 - {1'b0, k_reg});

        // Round to nearest, ties toward plus infinity.
        biased  = prod_reg + PROD_W'(32'sd32768);
        delta   = $signed(biased[PROD_W-1:16]);
        est_sum = EST_SUM_W'(delta) + EST_SUM_W'(est_reg);
        if (est_sum > EST_MAX)
        begin
            est_next = 16'sh7FFF;
        end
        else if (est_sum < EST_MIN)
        begin
            est_next = 16'sh8000;
        end
        else
        begin
            est_next = est_sum[15:0];
        end
        var_next = vprod_reg[31:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg <= EST_RESET;
            var_reg <= VAR_RESET;
        end
        else if (cmd.update)
        begin
            est_reg <= est_next;
            var_reg <= var_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            raw_reg <= raw_rssi;
        end
        if (cmd.predict)
        begin
            p_reg <= p_next;
        end
        if (cmd.div_init)
        begin
            sum_reg <= {1'b0, p_reg} + {1'b0, measurement_noise};
            rem_reg <= {1'b0, p_reg};
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[14:0], rem_ge};
        end
        if (cmd.gain)
        begin
            k_reg    <= k_next;
            diff_reg <= diff_next;
        end
        if (cmd.mult)
        begin
            prod_reg  <= prod_next;
            vprod_reg <= vprod_next;
        end
        if (cmd.load_out)
        begin
            out_est_reg <= est_reg;
            out_var_reg <= var_reg;
        end
    end

    assign filtered_rssi  = out_est_reg;
    assign error_variance = out_var_reg;

endmodule

>>> hdl/scalar_kalman_rssi_filter.sv
// Scalar Kalman RSSI filter, top level: register port, controller, datapath.
// A sample runs through predict, divider set-up, the 16-step gain divider, gain,
// multiply, update and done before m_tvalid; s_tready is high only when idle.
// The next sample is taken while a finished result still waits on the output.
// Reset (rst_n low, asynchronous) restores the estimate, variance and registers.
// Depends on skf_pkg, skf_ctrl and skf_datapath.
module scalar_kalman_rssi_filter
    import skf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] raw_rssi
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [15:0] filtered_rssi, [31:16] error_variance
);

    logic [15:0] pn_reg;
    logic [15:0] mn_reg;
    logic        wr_en;
    skf_cmd_t    cmd;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pn_reg <= PN_RESET;
            mn_reg <= MN_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_PROCESS_NOISE:     pn_reg <= pwdata[15:0];
                REG_MEASUREMENT_NOISE: mn_reg <= pwdata[15:0];
                default:               pn_reg <= pn_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_PROCESS_NOISE:     prdata = {16'd0, pn_reg};
            REG_MEASUREMENT_NOISE: prdata = {16'd0, mn_reg};
            default:               prdata = 32'd0;
        endcase
    end

    skf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    skf_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .raw_rssi          (s_tdata),
        .process_noise     (pn_reg),
        .measurement_noise (mn_reg),
        .filtered_rssi     (m_tdata[15:0]),
        .error_variance    (m_tdata[31:16])
    );

endmodule
